FILE: sv/periodic_catmull_rom_lookup_macros.svh
// Assertion helpers for the lookup block.
// Both expect clk_i and rst_ni in scope.
`ifndef PERIODIC_CATMULL_ROM_LOOKUP_MACROS_SVH
`define PERIODIC_CATMULL_ROM_LOOKUP_MACROS_SVH

// Same-cycle implication.
`define PCRL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcrl: same-cycle check failed");

// Next-cycle implication.
`define PCRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcrl: next-cycle check failed");

`endif

FILE: sv/pcrl_pkg.sv
package pcrl_pkg;

  localparam int SAMPLES_DEF   = 256;
  localparam int FRAC_BITS_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 8;
  localparam int PHASE_W  = 24;
  localparam int RADIUS_W = 40;
  localparam int SLOPE_W  = 48;

  // Fraction bits of the angle gain.
  localparam int GAIN_FRAC = 16;

  // Neighbor taps per query: i-1, i, i+1, i+2.
  localparam int TAPS = 4;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [IDX_W-1:0]     sample_index;
    logic [VALUE_W-1:0]   sample_value;
    logic [PHASE_W-1:0]   phase;
  } in_item_t;

  typedef struct packed {
    logic signed [RADIUS_W-1:0] radius;
    logic signed [SLOPE_W-1:0]  slope;
  } out_item_t;

  // Element 0 is p0 (segment - 1) ... element 3 is p3 (segment + 2).
  typedef logic [TAPS-1:0][VALUE_W-1:0] taps_t;

  // round(samples / (2*pi) * 2^16); 2^16 / (2*pi) = 10430.378350470453
  function automatic int unsigned slope_gain(input int unsigned samples);
    longint unsigned scaled;
    scaled = 64'(samples) * 64'd10430378350470 + 64'd500000000;
    return 32'(scaled / 64'd1000000000);
  endfunction

endpackage

FILE: sv/pcrl_bank.sv
module pcrl_bank #(
  parameter int DEPTH = pcrl_pkg::SAMPLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [pcrl_pkg::VALUE_W-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  output logic [pcrl_pkg::VALUE_W-1:0] rd_data_o
);

  logic [pcrl_pkg::VALUE_W-1:0] mem_q [DEPTH];
  logic [pcrl_pkg::VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/pcrl_spline.sv
module pcrl_spline #(
  parameter int SAMPLES   = pcrl_pkg::SAMPLES_DEF,
  parameter int FRAC_BITS = pcrl_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s1_valid_i,
  output logic                 s1_ready_o,
  input  pcrl_pkg::taps_t      taps_i,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pcrl_pkg::out_item_t  out_data_o
);

  localparam int F = FRAC_BITS;

  // Bounds with M = 2^32-1: |a| <= M, |b| <= 6M, |c| <= 4M,
  // |q1| <= 10M+1, |e1| <= 24M+1, |q2| <= 11M+2, |d| <= 12.5M+1.
  localparam int SUM_W = 38;
  localparam int A_W   = 34;
  localparam int B_W   = 36;
  localparam int C_W   = 35;
  localparam int C3_W  = 37;
  localparam int Q1_W  = 37;
  localparam int E1_W  = 39;
  localparam int Q2_W  = 37;
  localparam int D_W   = 38;

  localparam int unsigned GAIN_VAL = pcrl_pkg::slope_gain(SAMPLES);
  localparam int K_W = $clog2(GAIN_VAL + 1);
  localparam logic [K_W-1:0] GAIN = K_W'(GAIN_VAL);

  localparam int CT_W  = C_W + F + 1;
  localparam int C3T_W = C3_W + F + 1;
  localparam int Q1T_W = Q1_W + F + 1;
  localparam int E1T_W = E1_W + F + 1;
  localparam int DS_W  = E1_W + F + 2;
  localparam int Q2T_W = Q2_W + F + 1;
  localparam int RS_W  = Q2_W + F + 2;
  localparam int DK_W  = D_W + K_W + 1;

  logic out_ready, st4_ready, st3_ready, st2_ready;

  // stage 2: polynomial coefficients
  logic                          st2_valid_q;
  logic signed [A_W-1:0]         st2_a_q, st2_a_d;
  logic signed [B_W-1:0]         st2_b_q, st2_b_d;
  logic signed [C_W-1:0]         st2_c_q, st2_c_d;
  logic signed [C3_W-1:0]        st2_c3_q, st2_c3_d;
  logic [pcrl_pkg::VALUE_W-1:0]  st2_p1_q;
  logic [F-1:0]                  st2_t_q;

  // stage 3: first Horner step
  logic                          st3_valid_q;
  logic signed [Q1_W-1:0]        st3_q1_q, st3_q1_d;
  logic signed [E1_W-1:0]        st3_e1_q, st3_e1_d;
  logic signed [A_W-1:0]         st3_a_q;
  logic [pcrl_pkg::VALUE_W-1:0]  st3_p1_q;
  logic [F-1:0]                  st3_t_q;

  // stage 4: second Horner step
  logic                          st4_valid_q;
  logic signed [Q2_W-1:0]        st4_q2_q, st4_q2_d;
  logic signed [D_W-1:0]         st4_d_q, st4_d_d;
  logic [pcrl_pkg::VALUE_W-1:0]  st4_p1_q;
  logic [F-1:0]                  st4_t_q;

  // output register
  logic                          out_valid_q;
  pcrl_pkg::out_item_t           out_data_q, out_data_d;

  // valid/ready chain: a stage loads when empty or when it drains
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign st4_ready  = !st4_valid_q || out_ready;
  assign st3_ready  = !st3_valid_q || st4_ready;
  assign st2_ready  = !st2_valid_q || st3_ready;
  assign s1_ready_o = st2_ready;

  // ---- stage 1 -> 2: coefficients ----
  logic signed [SUM_W-1:0] p0s, p1s, p2s, p3s, a_c, b_c, c_c;

  always_comb begin
    p0s = SUM_W'($signed({1'b0, taps_i[0]}));
    p1s = SUM_W'($signed({1'b0, taps_i[1]}));
    p2s = SUM_W'($signed({1'b0, taps_i[2]}));
    p3s = SUM_W'($signed({1'b0, taps_i[3]}));
    a_c = p2s - p0s;
    b_c = (p0s <<< 1) - (p1s <<< 2) - p1s + (p2s <<< 2) - p3s;
    c_c = (p1s <<< 1) + p1s - (p2s <<< 1) - p2s + p3s - p0s;
    st2_a_d  = A_W'(a_c);
    st2_b_d  = B_W'(b_c);
    st2_c_d  = C_W'(c_c);
    st2_c3_d = C3_W'((c_c <<< 1) + c_c);
  end

  // ---- stage 2 -> 3: c*t and 3c*t ----
  logic signed [CT_W-1:0]  ct, ct_rnd;
  logic signed [C3T_W-1:0] c3t, c3t_rnd;

  always_comb begin
    ct       = st2_c_q * $signed({1'b0, st2_t_q});
    ct_rnd   = ct + (CT_W'(1) <<< (F - 1));
    c3t      = st2_c3_q * $signed({1'b0, st2_t_q});
    c3t_rnd  = c3t + (C3T_W'(1) <<< (F - 1));
    st3_q1_d = Q1_W'(ct_rnd >>> F) + Q1_W'(st2_b_q);
    st3_e1_d = E1_W'(c3t_rnd >>> F) + (E1_W'(st2_b_q) <<< 1);
  end

  // ---- stage 3 -> 4: q1*t and e1*t ----
  logic signed [Q1T_W-1:0] q1t, q1t_rnd;
  logic signed [E1T_W-1:0] e1t;
  logic signed [DS_W-1:0]  dsum;

  always_comb begin
    q1t      = st3_q1_q * $signed({1'b0, st3_t_q});
    q1t_rnd  = q1t + (Q1T_W'(1) <<< (F - 1));
    st4_q2_d = Q2_W'(q1t_rnd >>> F) + Q2_W'(st3_a_q);
    e1t      = st3_e1_q * $signed({1'b0, st3_t_q});
    dsum     = DS_W'(e1t) + (DS_W'(st3_a_q) <<< F) + (DS_W'(1) <<< F);
    st4_d_d  = D_W'(dsum >>> (F + 1));
  end

  // ---- stage 4 -> out: q2*t and d*gain ----
  // Both results stay far inside their output ranges, so no clamp.
  logic signed [Q2T_W-1:0] q2t;
  logic signed [RS_W-1:0]  rsum;
  logic signed [DK_W-1:0]  dk, dk_rnd;

  always_comb begin
    q2t    = st4_q2_q * $signed({1'b0, st4_t_q});
    rsum   = RS_W'(q2t) + (RS_W'($signed({1'b0, st4_p1_q})) <<< (F + 1))
             + (RS_W'(1) <<< F);
    dk     = st4_d_q * $signed({1'b0, GAIN});
    dk_rnd = dk + (DK_W'(1) <<< (pcrl_pkg::GAIN_FRAC - 1));
    out_data_d.radius = pcrl_pkg::RADIUS_W'(rsum >>> (F + 1));
    out_data_d.slope  = pcrl_pkg::SLOPE_W'(dk_rnd >>> pcrl_pkg::GAIN_FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st2_valid_q <= 1'b0;
      st3_valid_q <= 1'b0;
      st4_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (st2_ready) st2_valid_q <= s1_valid_i;
      if (st3_ready) st3_valid_q <= st2_valid_q;
      if (st4_ready) st4_valid_q <= st3_valid_q;
      if (out_ready) out_valid_q <= st4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st2_ready) begin
      st2_a_q  <= st2_a_d;
      st2_b_q  <= st2_b_d;
      st2_c_q  <= st2_c_d;
      st2_c3_q <= st2_c3_d;
      st2_p1_q <= taps_i[1];
      st2_t_q  <= t_i;
    end
    if (st3_ready) begin
      st3_q1_q <= st3_q1_d;
      st3_e1_q <= st3_e1_d;
      st3_a_q  <= st2_a_q;
      st3_p1_q <= st2_p1_q;
      st3_t_q  <= st2_t_q;
    end
    if (st4_ready) begin
      st4_q2_q <= st4_q2_d;
      st4_d_q  <= st4_d_d;
      st4_p1_q <= st3_p1_q;
      st4_t_q  <= st3_t_q;
    end
    if (out_ready) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/periodic_catmull_rom_lookup.sv
// A query passes stage 1 (bank read), stages 2..4 and the output register in order.
// Throughput: one transaction per cycle unless stalled, writes and queries mixed freely.
// Rate is set by the five-register pipeline and four table banks read in parallel.
// Writes take effect at their accepting edge and produce no result.
// Reset (rst_ni, async, active low) empties the pipeline; the table is not cleared.
`include "periodic_catmull_rom_lookup_macros.svh"

module periodic_catmull_rom_lookup #(
  parameter int SAMPLES   = pcrl_pkg::SAMPLES_DEF,
  parameter int FRAC_BITS = pcrl_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcrl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcrl_pkg::out_item_t out_data_o
);

  localparam int SEG_W  = $clog2(SAMPLES);
  localparam int PROD_W = pcrl_pkg::PHASE_W + SEG_W;
  localparam int CMP_W  = ((SEG_W > pcrl_pkg::IDX_W) ? SEG_W : pcrl_pkg::IDX_W) + 1;
  localparam logic [SEG_W-1:0] LAST = SEG_W'(SAMPLES - 1);

  // Handshake. The first stage is the registered read of the banks, so a
  // new transaction is taken whenever that stage is empty or moving on.
  logic in_accept, query_acc, write_acc, idx_in_range;
  logic st1_valid_q, st1_ready, s2_ready;

  assign st1_ready  = !st1_valid_q || s2_ready;
  assign in_stall_o = !st1_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign query_acc  = in_accept && (in_data_i.opcode == pcrl_pkg::OP_QUERY);

  // Writes past the ring are dropped.
  assign idx_in_range = CMP_W'(in_data_i.sample_index) < CMP_W'(SAMPLES);
  assign write_acc    = in_accept && (in_data_i.opcode == pcrl_pkg::OP_WRITE)
                        && idx_in_range;

  // Phase split: u = phase * SAMPLES / 2^24. Integer part is the segment,
  // the top FRAC_BITS of the fraction are t. For a power-of-two ring the
  // product is just a shift.
  logic [PROD_W-1:0]    prod;
  logic [SEG_W-1:0]     seg;
  logic [FRAC_BITS-1:0] t_c;

  assign prod = PROD_W'(in_data_i.phase) * PROD_W'(SAMPLES);
  assign seg  = prod[PROD_W-1 -: SEG_W];
  assign t_c  = prod[pcrl_pkg::PHASE_W-1 -: FRAC_BITS];

  // Neighbor addresses wrap around the ring.
  logic [SEG_W-1:0] bank_addr [pcrl_pkg::TAPS];

  always_comb begin
    bank_addr[0] = (seg == '0) ? LAST : seg - SEG_W'(1);
    bank_addr[1] = seg;
    bank_addr[2] = (seg == LAST) ? '0 : seg + SEG_W'(1);
    if (seg == LAST) begin
      bank_addr[3] = SEG_W'(1);
    end else if (seg == LAST - SEG_W'(1)) begin
      bank_addr[3] = '0;
    end else begin
      bank_addr[3] = seg + SEG_W'(2);
    end
  end

  // Four identical copies of the table, one per tap, so all four
  // neighbors come out in the same cycle. Every write goes to all of them.
  logic [pcrl_pkg::VALUE_W-1:0] bank_rd [pcrl_pkg::TAPS];

  for (genvar g = 0; g < pcrl_pkg::TAPS; g++) begin : g_bank
    pcrl_bank #(
      .DEPTH(SAMPLES)
    ) u_bank (
      .clk_i     (clk_i),
      .wr_en_i   (write_acc),
      .wr_addr_i (SEG_W'(in_data_i.sample_index)),
      .wr_data_i (in_data_i.sample_value),
      .rd_en_i   (query_acc),
      .rd_addr_i (bank_addr[g]),
      .rd_data_o (bank_rd[g])
    );
  end

  pcrl_pkg::taps_t      st1_taps;
  logic [FRAC_BITS-1:0] st1_t_q;

  assign st1_taps = {bank_rd[3], bank_rd[2], bank_rd[1], bank_rd[0]};

  // Stage 1 valid: only queries enter the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
    end else if (st1_ready) begin
      st1_valid_q <= query_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      st1_t_q <= t_c;
    end
  end

  // Stages 2..4 and the output register: coefficients, then Horner
  // steps for radius and d/dt, then the angle gain.
  pcrl_spline #(
    .SAMPLES  (SAMPLES),
    .FRAC_BITS(FRAC_BITS)
  ) u_spline (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (st1_valid_q),
    .s1_ready_o  (s2_ready),
    .taps_i      (st1_taps),
    .t_i         (st1_t_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The input only stalls behind an occupied first stage.
  `PCRL_ASSERT_NOW(a_stall_needs_st1, in_stall_o, st1_valid_q)
  // An accepted query always lands in stage 1.
  `PCRL_ASSERT_NEXT(a_query_enters, query_acc, st1_valid_q)
  // A write never occupies the pipeline.
  `PCRL_ASSERT_NEXT(a_write_no_item,
    in_accept && (in_data_i.opcode == pcrl_pkg::OP_WRITE), !st1_valid_q)

endmodule
